### rtl/raster_point_in_shape_test_unit_defines.svh
// Assertion macros for the raster point-in-shape test unit.
`ifndef RASTER_POINT_IN_SHAPE_TEST_UNIT_DEFINES_SVH
`define RASTER_POINT_IN_SHAPE_TEST_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RPIST_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rpist check failed");

// Next-cycle implication, disabled during reset.
`define RPIST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rpist check failed");

`endif

### rtl/rpist_pkg.sv
// Shared types and codes of the raster point-in-shape test unit.
`timescale 1ns / 1ps
`default_nettype none

package rpist_pkg;

   localparam int COORD_W   = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 8;
   localparam int CHUNK_W   = 64;

   typedef logic [COORD_W-1:0]   coord_type;
   typedef logic [1:0]           verdict_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam verdict_type VERDICT_OUTSIDE      = 2'd0;
   localparam verdict_type VERDICT_INSIDE       = 2'd1;
   localparam verdict_type VERDICT_UNDETERMINED = 2'd2;

   localparam csr_idx_type REG_BOX_COL_MIN = 3'd0;
   localparam csr_idx_type REG_BOX_ROW_MIN = 3'd1;
   localparam csr_idx_type REG_BOX_COL_MAX = 3'd2;
   localparam csr_idx_type REG_BOX_ROW_MAX = 3'd3;

endpackage

`default_nettype wire

### rtl/raster_point_in_shape_test_unit.sv
// Top level of the raster point-in-shape test unit.
// Usage:
//   req_ channel: one item is a pixel write (operation 0, bitmap-relative col/row,
//   pixel_value) or a point query (operation 1, absolute col/row).
//   rsp_ channel: one item per request; verdict 0 outside/on outline, 1 inside,
//   2 undetermined; was_query 0 marks a write acknowledge.
//   csr_ port: write-only box registers, taken at any edge with csr_wr_en high out of reset.
// Timing:
//   A write result is loaded from the READ state, a query result from the REDUCE
//   state after the registered run-parity XOR tree. req_ready is high only while
//   idle, so no new item is taken until the last result is loaded; writes do a
//   read-modify-write of the row-major and column-major line memories.
// Reset:
//   Both line memories are swept to zero, one line per cycle, over all GRID_SIDE lines;
//   req_ready stays low during the sweep. Box registers return to 0..255.
// Stall:
//   A result waits in the output register while rsp_ready is low. The next item
//   is still accepted; its finished result is held until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module raster_point_in_shape_test_unit
   import rpist_pkg::*;
#(
   parameter int GRID_SIDE = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_operation,
   input  wire coord_type   req_col,
   input  wire coord_type   req_row,
   input  wire logic        req_pixel_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output verdict_type      rsp_verdict,
   output logic             rsp_was_query,
   input  wire logic        csr_wr_en,
   input  wire csr_idx_type csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata
);

   localparam int AW = $clog2(GRID_SIDE);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_READ   = 2'd2;
   localparam logic [1:0] ST_REDUCE = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;

   coord_type box_col_min_ff, box_row_min_ff, box_col_max_ff, box_row_max_ff;

   logic      op_ff, pix_ff, in_box_ff, hit_ff;
   coord_type a_col_ff, a_row_ff;
   coord_type a_col_in, a_row_in;
   logic      in_box_in;

   logic        rsp_valid_ff, rsp_valid_in;
   verdict_type rsp_verdict_ff, verdict_in;
   logic        rsp_was_query_ff;

   logic accept, out_free, load_out, col_ok, row_ok;
   logic h_par, v_par, par_load;

   logic [GRID_SIDE-1:0] q_row, q_col, row_word, col_word, row_new, col_new;
   logic [GRID_SIDE-1:0] row_wdata, col_wdata;
   logic [AW-1:0]        row_waddr, col_waddr;
   logic                 mem_wr_en;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign in_box_in = (req_col >= box_col_min_ff) && (req_col <= box_col_max_ff) &&
                      (req_row >= box_row_min_ff) && (req_row <= box_row_max_ff);
   assign a_col_in  = (req_operation == OP_QUERY) ? req_col - box_col_min_ff : req_col;
   assign a_row_in  = (req_operation == OP_QUERY) ? req_row - box_row_min_ff : req_row;

   assign col_ok = 32'(a_col_ff) < GRID_SIDE;
   assign row_ok = 32'(a_row_ff) < GRID_SIDE;

   rpist_line_ram #(.DEPTH(GRID_SIDE), .WIDTH(GRID_SIDE)) u_row_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (row_waddr),
      .wr_data (row_wdata),
      .rd_en   (accept),
      .rd_addr (AW'(a_row_in)),
      .rd_data (q_row)
   );

   rpist_line_ram #(.DEPTH(GRID_SIDE), .WIDTH(GRID_SIDE)) u_col_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (col_waddr),
      .wr_data (col_wdata),
      .rd_en   (accept),
      .rd_addr (AW'(a_col_in)),
      .rd_data (q_col)
   );

   always_comb begin
      row_word = row_ok ? q_row : '0;
      col_word = col_ok ? q_col : '0;
      row_new  = q_row;
      col_new  = q_col;
      row_new[AW'(a_col_ff)] = pix_ff;
      col_new[AW'(a_row_ff)] = pix_ff;
      if (state_ff == ST_CLEAR) begin
         mem_wr_en = 1'b1;
         row_waddr = clr_cnt_ff;
         col_waddr = clr_cnt_ff;
         row_wdata = '0;
         col_wdata = '0;
      end else begin
         mem_wr_en = (state_ff == ST_READ) && (op_ff == OP_WRITE) && col_ok && row_ok;
         row_waddr = AW'(a_row_ff);
         col_waddr = AW'(a_col_ff);
         row_wdata = row_new;
         col_wdata = col_new;
      end
   end

   assign par_load = (state_ff == ST_READ) && (op_ff == OP_QUERY);

   rpist_run_parity #(.LINE_W(GRID_SIDE)) u_row_parity (
      .clock  (clock),
      .load   (par_load),
      .line   (row_word),
      .len    (a_col_ff),
      .parity (h_par)
   );

   rpist_run_parity #(.LINE_W(GRID_SIDE)) u_col_parity (
      .clock  (clock),
      .load   (par_load),
      .line   (col_word),
      .len    (a_row_ff),
      .parity (v_par)
   );

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      load_out   = 1'b0;
      verdict_in = VERDICT_OUTSIDE;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == AW'(GRID_SIDE - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (op_ff == OP_QUERY) begin
               state_in = ST_REDUCE;
            end else if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_REDUCE: begin
            if (!in_box_ff || hit_ff) begin
               verdict_in = VERDICT_OUTSIDE;
            end else if (h_par != v_par) begin
               verdict_in = VERDICT_UNDETERMINED;
            end else begin
               verdict_in = h_par ? VERDICT_INSIDE : VERDICT_OUTSIDE;
            end
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = load_out || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_col_min_ff <= '0;
         box_row_min_ff <= '0;
         box_col_max_ff <= '1;
         box_row_max_ff <= '1;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_BOX_COL_MIN: box_col_min_ff <= csr_wdata;
            REG_BOX_ROW_MIN: box_row_min_ff <= csr_wdata;
            REG_BOX_COL_MAX: box_col_max_ff <= csr_wdata;
            REG_BOX_ROW_MAX: box_row_max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_operation;
         pix_ff    <= req_pixel_value;
         in_box_ff <= in_box_in;
         a_col_ff  <= a_col_in;
         a_row_ff  <= a_row_in;
      end
      if (par_load) begin
         hit_ff <= col_ok && row_word[AW'(a_col_ff)];
      end
      if (load_out) begin
         rsp_verdict_ff   <= verdict_in;
         rsp_was_query_ff <= op_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_verdict   = rsp_verdict_ff;
   assign rsp_was_query = rsp_was_query_ff;

endmodule

`default_nettype wire

### rtl/rpist_line_ram.sv
// One-write one-read synchronous line memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rpist_line_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 256
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/rpist_run_parity.sv
// Parity of run starts in the first len bits of a line, via a registered XOR tree.
`timescale 1ns / 1ps
`default_nettype none

module rpist_run_parity
   import rpist_pkg::*;
#(
   parameter int LINE_W = 256
) (
   input  wire logic              clock,
   input  wire logic              load,
   input  wire logic [LINE_W-1:0] line,
   input  wire coord_type         len,
   output logic                   parity
);

   localparam int NCH   = (LINE_W + CHUNK_W - 1) / CHUNK_W;
   localparam int PAD_W = NCH * CHUNK_W;

   logic [LINE_W-1:0] prev_line;
   logic [PAD_W-1:0]  starts;
   logic [NCH-1:0]    part_in;
   logic [NCH-1:0]    part_ff;

   assign prev_line = {line[LINE_W-2:0], 1'b0};

   always_comb begin
      starts = '0;
      for (int i = 0; i < LINE_W; i++) begin
         starts[i] = line[i] & ~prev_line[i] & (i < int'(len));
      end
      for (int k = 0; k < NCH; k++) begin
         part_in[k] = ^starts[k*CHUNK_W +: CHUNK_W];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         part_ff <= part_in;
      end
   end

   assign parity = ^part_ff;

endmodule

`default_nettype wire

### rtl/rpist_checker.sv
// Port-level checker of the raster point-in-shape test unit, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "raster_point_in_shape_test_unit_defines.svh"

module rpist_checker
   import rpist_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire verdict_type rsp_verdict,
   input wire logic        rsp_was_query
);

   // a stalled result holds
   `RPIST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_verdict) && $stable(rsp_was_query))

   // a write acknowledge never carries a verdict
   `RPIST_ASSERT_NOW(a_ack_zero, clock, reset, rsp_valid && !rsp_was_query, rsp_verdict == VERDICT_OUTSIDE)

   // no result shows up in the cycle after an item is taken into an empty output
   `RPIST_ASSERT_NEXT(a_min_latency, clock, reset, req_valid && req_ready && (!rsp_valid || rsp_ready), !rsp_valid)

   // the clearing sweep blocks items right after reset
   `RPIST_ASSERT_NOW(a_clear_blocks, clock, reset, $past(reset), !req_ready)

endmodule

bind raster_point_in_shape_test_unit rpist_checker u_rpist_checker (.*);

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for the raster point-in-shape test unit.
`timescale 1ns / 1ps

module tb;
   import rpist_pkg::*;

   localparam int RANDOM_ITEMS = 600;
   localparam int DIR_STEPS    = 29;

   typedef enum logic {ROW_ITEM, ROW_BOX} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic         op;
      coord_type    col;
      coord_type    row;
      logic         pv;
      logic         typed;
      verdict_type  exp_v;
      coord_type    cmin;
      coord_type    rmin;
      coord_type    cmax;
      coord_type    rmax;
      logic         junk;
   } dir_step_type;

   typedef struct packed {
      verdict_type verdict;
      logic        was_query;
   } result_type;

   typedef struct packed {
      coord_type c;
      coord_type r;
   } pixel_pos_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_operation = OP_WRITE;
   coord_type   req_col = '0;
   coord_type   req_row = '0;
   logic        req_pixel_value = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   verdict_type rsp_verdict;
   logic        rsp_was_query;
   logic        csr_wr_en = 1'b0;
   csr_idx_type csr_index = REG_BOX_COL_MIN;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   // shape model: bitmap indexed [row][col] and box registers
   bit        outline_model [256][256];
   coord_type box_cmin = 8'd0;
   coord_type box_rmin = 8'd0;
   coord_type box_cmax = 8'd255;
   coord_type box_rmax = 8'd255;

   result_type    pending_results [$];
   pixel_pos_type outline_pixels [$];
   dir_step_type  dir_steps [DIR_STEPS];
   int            error_count = 0;
   int            items_sent = 0;
   int            burst_left = 0;
   bit            hold_off_req = 1'b0;
   bit            hold_off_done = 1'b0;

   raster_point_in_shape_test_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_col         (req_col),
      .req_row         (req_row),
      .req_pixel_value (req_pixel_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_verdict     (rsp_verdict),
      .rsp_was_query   (rsp_was_query),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("%0t: mismatch on %s: got %0h want %0h", $time, what, got, want);
      error_count++;
   endtask

   // parity of run starts left of and above the point, per axis
   function automatic verdict_type ray_cast_verdict(input coord_type c, input coord_type r);
      int rc;
      int rr;
      bit h_par;
      bit v_par;
      bit prev;
      if (!(c >= box_cmin && c <= box_cmax && r >= box_rmin && r <= box_rmax))
         return VERDICT_OUTSIDE;
      rc = int'(c) - int'(box_cmin);
      rr = int'(r) - int'(box_rmin);
      if (outline_model[rr][rc])
         return VERDICT_OUTSIDE;
      h_par = 1'b0;
      prev = 1'b0;
      for (int i = 0; i < rc; i++) begin
         if (outline_model[rr][i] && !prev)
            h_par = ~h_par;
         prev = outline_model[rr][i];
      end
      v_par = 1'b0;
      prev = 1'b0;
      for (int i = 0; i < rr; i++) begin
         if (outline_model[i][rc] && !prev)
            v_par = ~v_par;
         prev = outline_model[i][rc];
      end
      if (h_par != v_par)
         return VERDICT_UNDETERMINED;
      return h_par ? VERDICT_INSIDE : VERDICT_OUTSIDE;
   endfunction

   task automatic push_item(input logic op, input coord_type c, input coord_type r,
                            input logic pv, input logic typed, input verdict_type typed_v);
      result_type want;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 10);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_col         <= c;
      req_row         <= r;
      req_pixel_value <= pv;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      items_sent++;
      want.was_query = op;
      if (op == OP_WRITE) begin
         outline_model[r][c] = pv;
         if (pv)
            outline_pixels.push_back('{c: c, r: r});
         want.verdict = VERDICT_OUTSIDE;
      end else begin
         want.verdict = ray_cast_verdict(c, r);
      end
      if (typed)
         want.verdict = typed_v;
      pending_results.push_back(want);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_box(input coord_type cmin, input coord_type rmin,
                          input coord_type cmax, input coord_type rmax, input logic junk);
      csr_idx_type idx [4];
      coord_type   vals [4];
      idx  = '{REG_BOX_COL_MIN, REG_BOX_ROW_MIN, REG_BOX_COL_MAX, REG_BOX_ROW_MAX};
      vals = '{cmin, rmin, cmax, rmax};
      for (int i = 0; i < 4; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      if (junk) begin
         // unmapped index, must be ignored
         csr_index <= csr_idx_type'($urandom_range(int'(REG_BOX_ROW_MAX) + 1,
                                                   (1 << CSR_IDX_W) - 1));
         csr_wdata <= CSR_DAT_W'($urandom);
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      box_cmin = cmin;
      box_rmin = rmin;
      box_cmax = cmax;
      box_rmax = rmax;
   endtask

   // result side: checks and stall pattern, one long hold-off on request
   initial begin : rsp_side
      int         mode;
      int         mode_left;
      int         hold_left;
      result_type want;
      mode = 0;
      mode_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result with none pending", 8'(rsp_verdict), 8'hff);
            end else begin
               want = pending_results.pop_front();
               if (rsp_verdict !== want.verdict)
                  report_mismatch("verdict", 8'(rsp_verdict), 8'(want.verdict));
               if (rsp_was_query !== want.was_query)
                  report_mismatch("was_query", 8'(rsp_was_query), 8'(want.was_query));
            end
         end
         if (hold_off_req && !hold_off_done) begin
            hold_left = 120;
            hold_off_done = 1'b1;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(16, 80);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("FAIL raster_point_in_shape_test_unit");
      $finish;
   end

   initial begin : stim
      int            first_random;
      int            x0;
      int            y0;
      int            w;
      int            h;
      int            nq;
      coord_type     cmin;
      coord_type     rmin;
      coord_type     cmax;
      coord_type     rmax;
      coord_type     qc;
      coord_type     qr;
      pixel_pos_type p;

      dir_steps = '{
         '{ROW_ITEM, OP_QUERY, 0,   0,   0, 1, VERDICT_OUTSIDE, 0, 0, 0, 0, 0},
         '{ROW_ITEM, OP_QUERY, 255, 255, 0, 1, VERDICT_OUTSIDE, 0, 0, 0, 0, 0},
         '{ROW_ITEM, OP_WRITE, 0,   0,   1, 1, VERDICT_OUTSIDE, 0, 0, 0, 0, 0},
         '{ROW_ITEM, OP_QUERY, 0,   0,   1, 1, VERDICT_OUTSIDE, 0, 0, 0, 0, 0},
         '{ROW_ITEM, OP_WRITE, 255, 255, 1, 1, VERDICT_OUTSIDE, 0, 0, 0, 0, 0},
         '{ROW_ITEM, OP_QUERY, 255, 255, 0, 1, VERDICT_OUTSIDE, 0, 0, 0, 0, 0},
         '{ROW_ITEM, OP_WRITE, 2,   2,   1, 1, VERDICT_OUTSIDE, 0, 0, 0, 0, 0},
         '{ROW_ITEM, OP_WRITE, 3,   2,   1, 1, VERDICT_OUTSIDE, 0, 0, 0, 0, 0},
         '{ROW_ITEM, OP_WRITE, 4,   2,   1, 1, VERDICT_OUTSIDE, 0, 0, 0, 0, 0},
         '{ROW_ITEM, OP_WRITE, 2,   3,   1, 1, VERDICT_OUTSIDE, 0, 0, 0, 0, 0},
         '{ROW_ITEM, OP_WRITE, 4,   3,   1, 1, VERDICT_OUTSIDE, 0, 0, 0, 0, 0},
         '{ROW_ITEM, OP_WRITE, 2,   4,   1, 1, VERDICT_OUTSIDE, 0, 0, 0, 0, 0},
         '{ROW_ITEM, OP_WRITE, 3,   4,   1, 1, VERDICT_OUTSIDE, 0, 0, 0, 0, 0},
         '{ROW_ITEM, OP_WRITE, 4,   4,   1, 1, VERDICT_OUTSIDE, 0, 0, 0, 0, 0},
         '{ROW_ITEM, OP_QUERY, 3,   3,   0, 0, VERDICT_OUTSIDE, 0, 0, 0, 0, 0},
         '{ROW_ITEM, OP_QUERY, 5,   2,   1, 0, VERDICT_OUTSIDE, 0, 0, 0, 0, 0},
         '{ROW_ITEM, OP_QUERY, 3,   5,   0, 0, VERDICT_OUTSIDE, 0, 0, 0, 0, 0},
         '{ROW_ITEM, OP_WRITE, 0,   0,   0, 1, VERDICT_OUTSIDE, 0, 0, 0, 0, 0},
         '{ROW_ITEM, OP_QUERY, 0,   0,   0, 0, VERDICT_OUTSIDE, 0, 0, 0, 0, 0},
         '{ROW_BOX,  OP_WRITE, 0,   0,   0, 0, VERDICT_OUTSIDE, 250, 250, 255, 255, 0},
         '{ROW_ITEM, OP_QUERY, 249, 250, 0, 1, VERDICT_OUTSIDE, 0, 0, 0, 0, 0},
         '{ROW_ITEM, OP_QUERY, 253, 253, 0, 0, VERDICT_OUTSIDE, 0, 0, 0, 0, 0},
         '{ROW_ITEM, OP_QUERY, 255, 255, 1, 0, VERDICT_OUTSIDE, 0, 0, 0, 0, 0},
         // empty box in columns, plus an unmapped register write
         '{ROW_BOX,  OP_WRITE, 0,   0,   0, 0, VERDICT_OUTSIDE, 10, 250, 5, 255, 1},
         '{ROW_ITEM, OP_QUERY, 7,   252, 0, 1, VERDICT_OUTSIDE, 0, 0, 0, 0, 0},
         '{ROW_ITEM, OP_WRITE, 255, 255, 0, 1, VERDICT_OUTSIDE, 0, 0, 0, 0, 0},
         '{ROW_ITEM, OP_QUERY, 255, 250, 0, 1, VERDICT_OUTSIDE, 0, 0, 0, 0, 0},
         '{ROW_BOX,  OP_WRITE, 0,   0,   0, 0, VERDICT_OUTSIDE, 0, 0, 255, 255, 0},
         '{ROW_ITEM, OP_QUERY, 3,   3,   0, 0, VERDICT_OUTSIDE, 0, 0, 0, 0, 0}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // line memories are swept after reset
      do @(posedge clock); while (!req_ready);

      for (int i = 0; i < DIR_STEPS; i++) begin
         if (dir_steps[i].kind == ROW_BOX) begin
            drain_results();
            set_box(dir_steps[i].cmin, dir_steps[i].rmin, dir_steps[i].cmax,
                    dir_steps[i].rmax, dir_steps[i].junk);
         end else begin
            push_item(dir_steps[i].op, dir_steps[i].col, dir_steps[i].row,
                      dir_steps[i].pv, dir_steps[i].typed, dir_steps[i].exp_v);
         end
      end

      first_random = items_sent;
      while (items_sent < first_random + RANDOM_ITEMS) begin
         drain_results();
         case ($urandom_range(0, 9))
            0: begin
               cmin = 8'd0; rmin = 8'd0; cmax = 8'd255; rmax = 8'd255;
            end
            1: begin
               cmin = coord_type'($urandom_range(1, 255));
               cmax = coord_type'($urandom_range(0, int'(cmin) - 1));
               rmin = coord_type'($urandom_range(0, 100));
               rmax = coord_type'($urandom_range(int'(rmin), 255));
            end
            2: begin
               rmin = coord_type'($urandom_range(1, 255));
               rmax = coord_type'($urandom_range(0, int'(rmin) - 1));
               cmin = coord_type'($urandom_range(0, 100));
               cmax = coord_type'($urandom_range(int'(cmin), 255));
            end
            3: begin
               cmin = 8'd0; rmin = 8'd0; cmax = 8'd0; rmax = 8'd0;
            end
            4: begin
               cmin = 8'd255; rmin = 8'd255; cmax = 8'd255; rmax = 8'd255;
            end
            default: begin
               cmin = coord_type'($urandom_range(0, 160));
               cmax = coord_type'($urandom_range(int'(cmin), 255));
               rmin = coord_type'($urandom_range(0, 160));
               rmax = coord_type'($urandom_range(int'(rmin), 255));
            end
         endcase
         set_box(cmin, rmin, cmax, rmax, $urandom_range(0, 3) == 0);

         // erase the previous shape
         while (outline_pixels.size() != 0) begin
            p = outline_pixels.pop_front();
            push_item(OP_WRITE, p.c, p.r, 1'b0, 1'b0, VERDICT_OUTSIDE);
         end

         x0 = $urandom_range(0, 40);
         y0 = $urandom_range(0, 40);
         w  = $urandom_range(3, 12);
         h  = $urandom_range(3, 12);
         for (int i = 0; i < w; i++) begin
            push_item(OP_WRITE, coord_type'(x0 + i), coord_type'(y0), 1'b1, 1'b0,
                      VERDICT_OUTSIDE);
            push_item(OP_WRITE, coord_type'(x0 + i), coord_type'(y0 + h - 1), 1'b1, 1'b0,
                      VERDICT_OUTSIDE);
         end
         for (int j = 1; j < h - 1; j++) begin
            push_item(OP_WRITE, coord_type'(x0), coord_type'(y0 + j), 1'b1, 1'b0,
                      VERDICT_OUTSIDE);
            push_item(OP_WRITE, coord_type'(x0 + w - 1), coord_type'(y0 + j), 1'b1, 1'b0,
                      VERDICT_OUTSIDE);
         end
         repeat ($urandom_range(0, 3))
            push_item(OP_WRITE, coord_type'($urandom), coord_type'($urandom),
                      1'($urandom), 1'b0, VERDICT_OUTSIDE);

         hold_off_req = 1'b1;
         nq = $urandom_range(15, 40);
         for (int q = 0; q < nq; q++) begin
            if ($urandom_range(0, 4) != 0) begin
               qc = coord_type'(int'(box_cmin) + x0 - 3 + $urandom_range(0, w + 5));
               qr = coord_type'(int'(box_rmin) + y0 - 3 + $urandom_range(0, h + 5));
            end else begin
               qc = coord_type'($urandom);
               qr = coord_type'($urandom);
            end
            push_item(OP_QUERY, qc, qr, 1'($urandom), 1'b0, VERDICT_OUTSIDE);
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("PASS raster_point_in_shape_test_unit");
      else
         $display("FAIL raster_point_in_shape_test_unit");
      $finish;
   end

endmodule
